/* rtl/core/lps_pkg.sv */
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants of the learned peer selector: payload structs,
// operation codes and the command/status bundle between controller and
// datapath.
// ----------------------------------------------------------------------------
package lps_pkg;

	localparam int NUM_PEERS_DEF   = 16;
	localparam int NUM_QUERIES_DEF = 8;
	localparam int NUM_TYPES_DEF   = 4;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int MASK_WIDTH = 32;
	localparam logic [MASK_WIDTH-1:0] MASK_RESET = 32'h0008_6C13;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [2:0] query_id;
		logic [3:0] peer_id;
	} in_t;

	typedef struct packed {
		logic [3:0] chosen_peer;
		logic       found;
		logic       relaxed;
	} out_t;

	typedef struct packed {
		logic load;
		logic sel_init;
		logic scan_start;
		logic scan_step;
		logic sim_start;
		logic sim_step;
		logic relax;
		logic upd_wr;
		logic emit;
	} lps_cmd_t;

	typedef struct packed {
		logic q_oor;
		logic scan_done;
		logic hit;
		logic relaxed;
		logic sim_last;
		logic sim_hit;
		logic out_free;
	} lps_status_t;

endpackage

/* rtl/core/lps_ram.sv */
// ----------------------------------------------------------------------------
// lps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/lps_ctrl.sv */
// ----------------------------------------------------------------------------
// lps_ctrl
// Sequencer of the peer selector: takes one item at a time and steps the
// datapath through update, row scan, similarity search and result transfer.
// ----------------------------------------------------------------------------
module lps_ctrl
	import lps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_op,
	output logic        in_stall,
	input  lps_status_t status,
	output lps_cmd_t    cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_UPD_RD = 8'b0000_0010,
		S_UPD_WR = 8'b0000_0100,
		S_SEL    = 8'b0000_1000,
		S_SCAN   = 8'b0001_0000,
		S_CHECK  = 8'b0010_0000,
		S_SIM    = 8'b0100_0000,
		S_RESULT = 8'b1000_0000
	} lps_state_t;

	lps_state_t state_q;
	lps_state_t state_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = (in_op == OP_SELECT) ? S_SEL : S_UPD_RD;
				end
			end
			S_UPD_RD: begin
				state_d = S_UPD_WR;
			end
			S_UPD_WR: begin
				cmd.upd_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_SEL: begin
				cmd.sel_init = 1'b1;
				if (status.q_oor) begin
					state_d = S_RESULT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				// relax only once, and only after an empty primary row
				if (status.hit || status.relaxed) begin
					state_d = S_RESULT;
				end else begin
					cmd.sim_start = 1'b1;
					state_d       = S_SIM;
				end
			end
			S_SIM: begin
				cmd.sim_step = 1'b1;
				if (status.sim_last) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (status.sim_hit && !status.relaxed && !status.hit) begin
					cmd.relax      = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/lps_dp.sv */
// ----------------------------------------------------------------------------
// lps_dp
// Datapath of the peer selector: count table with valid bits, saturating
// update, sequential row argmax, similarity search over query type masks and
// the result register.
// ----------------------------------------------------------------------------
module lps_dp
	import lps_pkg::*;
#(
	parameter int NUM_PEERS   = NUM_PEERS_DEF,
	parameter int NUM_QUERIES = NUM_QUERIES_DEF,
	parameter int NUM_TYPES   = NUM_TYPES_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_t                   in_data,
	input  logic                  cfg_wr_en,
	input  logic [MASK_WIDTH-1:0] cfg_wr_data,
	input  logic                  out_stall,
	output logic                  out_valid,
	output out_t                  out_data,
	input  lps_cmd_t              cmd,
	output lps_status_t           status
);

	localparam int PW    = $clog2(NUM_PEERS);
	localparam int QW    = $clog2(NUM_QUERIES);
	localparam int AW    = QW + PW;
	localparam int DEPTH = 1 << AW;
	localparam int NQP2  = 1 << QW;
	localparam int CW    = PW + 1;
	localparam int SW    = $clog2(NUM_TYPES + 1);

	function automatic logic [SW-1:0] pop_count(input logic [NUM_TYPES-1:0] v);
		logic [SW-1:0] n;
		n = '0;
		for (int b = 0; b < NUM_TYPES; b++) begin
			n = n + SW'(v[b]);
		end
		return n;
	endfunction

	in_t                   item_q;
	logic [MASK_WIDTH-1:0] mask_q;
	logic [DEPTH-1:0]      vld_q;

	logic [4:0]            q_ext;
	logic [6:0]            p_ext;
	logic                  q_oor;
	logic                  p_oor;
	logic [QW-1:0]         item_row;
	logic [PW-1:0]         item_peer;

	logic [QW-1:0]         row_q;
	logic                  relaxed_q;
	logic [CW-1:0]         cnt_q;
	logic                  pend_s1;
	logic [PW-1:0]         pidx_s1;
	logic                  rd_vld_s1;
	logic [COUNT_WIDTH-1:0] best_q;
	logic [PW-1:0]         bestp_q;
	logic                  hit_q;

	logic [QW-1:0]         si_q;
	logic [SW-1:0]         sbest_q;
	logic [QW-1:0]         other_q;
	logic                  shit_q;
	logic [NUM_TYPES-1:0]  types [NQP2];
	logic [SW-1:0]         shared;
	logic                  sim_last;

	logic [AW-1:0]          raddr;
	logic [AW-1:0]          waddr;
	logic [COUNT_WIDTH-1:0] rdata;
	logic [COUNT_WIDTH-1:0] rd_val;
	logic [COUNT_WIDTH-1:0] wdata;
	logic                   we;

	logic                  out_valid_q;
	out_t                  out_q;
	logic [6:0]            bp_ext;

	assign q_ext     = 5'(item_q.query_id);
	assign p_ext     = 7'(item_q.peer_id);
	assign q_oor     = (q_ext >= 5'(NUM_QUERIES));
	assign p_oor     = (p_ext >= 7'(NUM_PEERS));
	assign item_row  = q_ext[QW-1:0];
	assign item_peer = p_ext[PW-1:0];

	// item and configuration
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_wr_en) begin
			mask_q <= cfg_wr_data;
		end
	end

	// count table
	assign raddr  = cmd.scan_step ? {row_q, cnt_q[PW-1:0]} : {item_row, item_peer};
	assign waddr  = {item_row, item_peer};
	assign rd_val = rd_vld_s1 ? rdata : '0;
	assign wdata  = (rd_val == '1) ? rd_val : rd_val + COUNT_WIDTH'(1);
	assign we     = cmd.upd_wr && !q_oor && !p_oor;

	lps_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[raddr];
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	// row scan: each read is issued in the cycle before its compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pend_s1   <= 1'b0;
			hit_q     <= 1'b0;
			row_q     <= '0;
			relaxed_q <= 1'b0;
		end else begin
			if (cmd.sel_init) begin
				row_q     <= item_row;
				relaxed_q <= 1'b0;
			end else if (cmd.relax) begin
				row_q     <= other_q;
				relaxed_q <= 1'b1;
			end
			if (cmd.sel_init || cmd.scan_start) begin
				cnt_q   <= '0;
				pend_s1 <= 1'b0;
				hit_q   <= 1'b0;
			end else if (cmd.scan_step) begin
				if (cnt_q != CW'(NUM_PEERS)) begin
					cnt_q <= cnt_q + CW'(1);
				end
				pend_s1 <= (cnt_q != CW'(NUM_PEERS));
				if (pend_s1 && (rd_val > best_q)) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sel_init || cmd.scan_start) begin
			best_q  <= '0;
			bestp_q <= '0;
		end else if (cmd.scan_step) begin
			pidx_s1 <= cnt_q[PW-1:0];
			if (pend_s1 && (rd_val > best_q)) begin
				best_q  <= rd_val;
				bestp_q <= pidx_s1;
			end
		end
	end

	// similarity search, one query class a cycle
	always_comb begin
		for (int k = 0; k < NQP2; k++) begin
			types[k] = NUM_TYPES'(mask_q >> (NUM_TYPES * k));
		end
	end

	assign shared   = pop_count(types[row_q] & types[si_q]);
	assign sim_last = (si_q == QW'(NUM_QUERIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			si_q    <= '0;
			shit_q  <= 1'b0;
			sbest_q <= '0;
		end else if (cmd.sim_start || cmd.sel_init) begin
			si_q    <= '0;
			shit_q  <= 1'b0;
			sbest_q <= '0;
		end else if (cmd.sim_step) begin
			if (!sim_last) begin
				si_q <= si_q + QW'(1);
			end
			if ((si_q != row_q) && (shared > sbest_q)) begin
				sbest_q <= shared;
				shit_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sim_step && (si_q != row_q) && (shared > sbest_q)) begin
			other_q <= si_q;
		end
	end

	// result register
	assign bp_ext = 7'(bestp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.chosen_peer <= hit_q ? bp_ext[3:0] : 4'd0;
			out_q.found       <= hit_q;
			out_q.relaxed     <= hit_q && relaxed_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		status.q_oor     = q_oor;
		status.scan_done = (cnt_q == CW'(NUM_PEERS)) && pend_s1;
		status.hit       = hit_q;
		status.relaxed   = relaxed_q;
		status.sim_last  = sim_last;
		status.sim_hit   = shit_q;
		status.out_free  = !out_valid_q || !out_stall;
	end

endmodule

/* rtl/core/learned_peer_selector_top.sv */
// ----------------------------------------------------------------------------
// learned_peer_selector_top
// Per-query, per-peer success counts with best-peer selection and one level
// of relaxation to the most similar query class.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_data): an update credits one peer of one
//   query class and returns nothing; a select returns one item on the out
//   channel (out_valid/out_stall/out_data).
//   cfg_wr_en/cfg_wr_data write the query type masks; write only while idle.
//   One item is processed at a time; in_stall is high until it is finished.
//   Update: the item passes a read state and a write state before the next
//   item can be taken. Select: a hit in the own row takes one row scan; an
//   empty own row adds the similarity search and, if a similar class is
//   found, a second scan. The scan reads one count per cycle from the table
//   RAM, and the similarity search checks one query class per cycle.
//   The result sits in an output register: a stalled result holds, and a
//   new item is still taken; its result waits until the register frees.
//   Reset clears every count (per-entry valid bits) and restores the masks.
// ----------------------------------------------------------------------------
module learned_peer_selector_top
	import lps_pkg::*;
#(
	parameter int NUM_PEERS   = NUM_PEERS_DEF,
	parameter int NUM_QUERIES = NUM_QUERIES_DEF,
	parameter int NUM_TYPES   = NUM_TYPES_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_wr_en,
	input  logic [MASK_WIDTH-1:0] cfg_wr_data
);

	lps_cmd_t    cmd;
	lps_status_t status;

	lps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.operation),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lps_dp #(
		.NUM_PEERS   (NUM_PEERS),
		.NUM_QUERIES (NUM_QUERIES),
		.NUM_TYPES   (NUM_TYPES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data),
		.cmd         (cmd),
		.status      (status)
	);

`ifndef NO_ASSERTIONS
	a_update_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (in_data.operation == OP_UPDATE)) |=> !$rose(out_valid))
		else $error("update transfer produced a result");

	a_relaxed_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.relaxed || out_data.found))
		else $error("relaxed set without a found peer");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.found) |-> (out_data.chosen_peer == 4'd0))
		else $error("nonzero peer reported with found low");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken while one is in work");
`endif

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for learned_peer_selector_top. A queue-fed driver
// sends update and select items in random bursts, and a monitor stalls the
// result channel on its own pattern. Each accepted transfer runs through a
// local model of the count table and the similarity search, and every
// result is compared field by field with the oldest expected pick. Phases
// run under several type-mask settings.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lps_pkg::*;

	localparam int PEERS        = NUM_PEERS_DEF;
	localparam int QUERIES      = NUM_QUERIES_DEF;
	localparam int TYPES        = NUM_TYPES_DEF;
	localparam int CW           = COUNT_WIDTH_DEF;
	localparam logic [CW-1:0] COUNT_TOP = {CW{1'b1}};
	// Full select: own scan, similarity search, second scan, plus margin.
	localparam int SETTLE_CYCLES = 2 * (QUERIES + 2 * PEERS + 8);
	localparam int PHASE_ITEMS   = 70;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} stall_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [MASK_WIDTH-1:0] cfg_wr_data = '0;

	learned_peer_selector_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Local copy of the block state
	logic [CW-1:0]         success_tally [QUERIES][PEERS];
	logic [MASK_WIDTH-1:0] type_masks;

	in_t  pending_items[$];
	out_t expected_picks[$];

	int unsigned n_queued, n_accepted, n_errors;
	int unsigned n_updates, n_own_hits, n_relaxed_hits, n_misses, n_settings;
	int unsigned gap_left, burst_left, stall_left;
	stall_kind_t stall_kind;

	function automatic logic [TYPES-1:0] class_types(int unsigned q);
		logic [MASK_WIDTH-1:0] shifted;
		if (TYPES * q >= MASK_WIDTH)
			return '0;
		shifted = type_masks >> (TYPES * q);
		return shifted[TYPES-1:0];
	endfunction

	function automatic bit best_in_row(int unsigned q, output logic [3:0] peer);
		logic [CW-1:0] top;
		bit            hit;
		top = '0;
		hit = 1'b0;
		peer = '0;
		for (int p = 0; p < PEERS; p++) begin
			if (success_tally[q][p] > top) begin
				top = success_tally[q][p];
				peer = 4'(p);
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic bit nearest_class(int unsigned q, output int unsigned other);
		logic [TYPES-1:0] own;
		int unsigned      top, n;
		bit               hit;
		own = class_types(q);
		top = 0;
		hit = 1'b0;
		other = 0;
		for (int i = 0; i < QUERIES; i++) begin
			if (i != q) begin
				n = $countones(own & class_types(i));
				if (n > top) begin
					top = n;
					other = i;
					hit = 1'b1;
				end
			end
		end
		return hit;
	endfunction

	// Apply one accepted transfer to the local table; a select yields a pick
	task automatic take_transfer(in_t item);
		out_t        pick;
		logic [3:0]  peer;
		int unsigned other;
		bit          hit, rel;
		if (item.operation == OP_UPDATE) begin
			n_updates++;
			if (item.query_id < QUERIES && item.peer_id < PEERS &&
			    success_tally[item.query_id][item.peer_id] != COUNT_TOP)
				success_tally[item.query_id][item.peer_id] += 1'b1;
		end else begin
			hit = 1'b0;
			rel = 1'b0;
			peer = '0;
			if (item.query_id < QUERIES) begin
				hit = best_in_row(item.query_id, peer);
				if (!hit && nearest_class(item.query_id, other)) begin
					hit = best_in_row(other, peer);
					rel = hit;
				end
			end
			if (!hit)
				peer = '0;
			if (!hit)
				n_misses++;
			else if (rel)
				n_relaxed_hits++;
			else
				n_own_hits++;
			pick.chosen_peer = peer;
			pick.found = hit;
			pick.relaxed = rel;
			expected_picks.push_back(pick);
		end
	endtask

	task automatic check_pick(out_t got);
		out_t want;
		if (expected_picks.size() == 0) begin
			n_errors++;
			$display("%0t: result with nothing expected: got %p", $time, got);
		end else begin
			want = expected_picks.pop_front();
			if (got.chosen_peer !== want.chosen_peer) begin
				n_errors++;
				$display("%0t: chosen_peer expected %0d got %0d", $time,
				         want.chosen_peer, got.chosen_peer);
			end
			if (got.found !== want.found) begin
				n_errors++;
				$display("%0t: found expected %0b got %0b", $time, want.found, got.found);
			end
			if (got.relaxed !== want.relaxed) begin
				n_errors++;
				$display("%0t: relaxed expected %0b got %0b", $time,
				         want.relaxed, got.relaxed);
			end
		end
	endtask

	// Driver: hold a stalled item, otherwise advance through bursts and gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				take_transfer(in_data);
				n_accepted++;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
					                                         : $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
				end
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer, stall in windows of varying density
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			stall_kind = STALL_NONE;
		end else begin
			if (out_valid && !out_stall)
				check_pick(out_data);
			if (stall_left == 0) begin
				stall_kind = stall_kind_t'($urandom_range(0, 3));
				stall_left = $urandom_range(1, 48);
			end
			stall_left--;
			case (stall_kind)
				STALL_NONE: begin
					out_stall <= 1'b0;
				end
				STALL_LIGHT: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				STALL_HEAVY: begin
					out_stall <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					out_stall <= 1'b1;
				end
			endcase
		end
	end

	task automatic queue_item(logic op, int unsigned q, int unsigned p);
		in_t item;
		item.operation = op;
		item.query_id = 3'(q);
		item.peer_id = 4'(p);
		pending_items.push_back(item);
		n_queued++;
	endtask

	task automatic write_masks(logic [MASK_WIDTH-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		type_masks = value;
		n_settings++;
	endtask

	// Wait until every item is taken and every pick has arrived, then settle
	task automatic drain();
		do
			@(negedge clk);
		while (n_accepted != n_queued || expected_picks.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [MASK_WIDTH-1:0] phase_masks [$];
		type_masks = MASK_RESET;
		for (int q = 0; q < QUERIES; q++)
			for (int p = 0; p < PEERS; p++)
				success_tally[q][p] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset masks: class0 {0,1}, class1 {0}, class2 {2,3}, class3 {1,2}, class4 {3}
		write_masks(MASK_RESET);
		queue_item(OP_SELECT, 0, 15);  // empty row, relaxed row empty too
		queue_item(OP_SELECT, 7, 0);   // no types: no similar class
		queue_item(OP_UPDATE, 0, 0);
		queue_item(OP_UPDATE, 0, 15);
		queue_item(OP_SELECT, 1, 3);   // relax to class0, tie goes to peer 0
		queue_item(OP_UPDATE, 0, 15);
		queue_item(OP_SELECT, 0, 0);   // own row hit, peer 15
		queue_item(OP_UPDATE, 2, 7);
		queue_item(OP_UPDATE, 2, 7);
		queue_item(OP_SELECT, 4, 9);   // relax to class2
		queue_item(OP_UPDATE, 3, 10);
		queue_item(OP_UPDATE, 3, 5);
		queue_item(OP_SELECT, 3, 15);  // tie in own row, lowest peer wins
		queue_item(OP_UPDATE, 5, 15);
		queue_item(OP_SELECT, 5, 0);
		queue_item(OP_SELECT, 6, 15);  // no types, not found
		queue_item(OP_SELECT, 2, 8);
		drain();

		// Rows 6 and 7 never get credit, so selects there always look for a similar class
		phase_masks.push_back('0);
		phase_masks.push_back('1);
		phase_masks.push_back(32'hFF00_0000);
		phase_masks.push_back($urandom());
		phase_masks.push_back($urandom());
		phase_masks.push_back($urandom());
		phase_masks.push_back(MASK_RESET);
		foreach (phase_masks[i]) begin
			write_masks(phase_masks[i]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 55)
					queue_item(OP_UPDATE, $urandom_range(0, 5), $urandom_range(0, 15));
				else
					queue_item(OP_SELECT, $urandom_range(0, 7), $urandom_range(0, 15));
			end
			drain();
		end

		$display("Run covered %0d items, %0d of them updates, under %0d mask settings.",
		         n_accepted, n_updates, n_settings);
		$display("Selects: %0d own-row hits, %0d relaxed hits, %0d with no peer found.",
		         n_own_hits, n_relaxed_hits, n_misses);
		if (n_errors == 0)
			$display("** learned_peer_selector_top: PASSED **");
		else
			$display("** learned_peer_selector_top: FAILED **");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout: %0d of %0d items taken, %0d picks outstanding",
		         n_accepted, n_queued, expected_picks.size());
		$display("** learned_peer_selector_top: FAILED **");
		$finish;
	end

endmodule
